@@ rtl/dime_rd_pkg.sv @@
package dime_rd_pkg;

  localparam int unsigned TDATA_W = 80;

  localparam logic [7:0] HDR_VER_MASK   = 8'hF8;
  localparam logic [7:0] HDR_VER        = 8'h08;
  localparam logic [7:0] HDR_TYPE_MEDIA = 8'h10;
  localparam logic [7:0] HDR_TYPE_URI   = 8'h20;

  localparam logic [3:0] HDR_IDX_FLAGS  = 4'd0;
  localparam logic [3:0] HDR_IDX_TYPE   = 4'd1;
  localparam logic [3:0] HDR_IDX_RSV0   = 4'd2;
  localparam logic [3:0] HDR_IDX_RSV1   = 4'd3;
  localparam logic [3:0] HDR_IDX_ID_HI  = 4'd4;
  localparam logic [3:0] HDR_IDX_ID_LO  = 4'd5;
  localparam logic [3:0] HDR_IDX_TY_HI  = 4'd6;
  localparam logic [3:0] HDR_IDX_TY_LO  = 4'd7;
  localparam logic [3:0] HDR_IDX_BODY   = 4'd8;
  localparam logic [3:0] HDR_IDX_LAST   = 4'd11;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ID       = 3'd1,
    PH_TYPE     = 3'd2,
    PH_BODY     = 3'd3,
    PH_PAD_ID   = 3'd4,
    PH_PAD_TYPE = 3'd5,
    PH_PAD_BODY = 3'd6,
    PH_ERROR    = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    CLS_ID      = 3'd0,
    CLS_TYPE    = 3'd1,
    CLS_BODY    = 3'd2,
    CLS_SUMMARY = 3'd3,
    CLS_ERROR   = 3'd4
  } cls_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data_byte;
    cls_e        byte_class;
    logic        section_last;
    logic        record_flag_a;
    logic        record_flag_b;
    logic        type_is_uri;
    logic [15:0] id_length;
    logic [15:0] type_length;
    logic [31:0] body_length;
  } result_t;

endpackage

@@ rtl/dime_record_deframer_top.sv @@
// DIME-style record header parser and deframer.
// Slave stream s_axis: one raw record byte per transfer in tdata.
// Master stream m_axis: at most one result per input byte. tuser carries
// the class (id, type, body, header summary, format error), tlast marks the
// final byte of the id, type or body section, tdata carries the byte or the
// summary fields. Header bytes before the twelfth and padding bytes give no
// transfer; a bad header byte gives one error transfer, after which all
// input is consumed and dropped until reset.
// Path: each input byte is held in an input register, then the parse logic
// writes its result into the output register.
// Throughput: one byte per cycle unless the output stalls, set by the single
// parse stage that updates the section counter and header state once per byte.
// Reset: all parse state returns to the start of a record header; both
// register stages empty. No clearing pass.
// Stall: while m_axis_tready_i is low the output register holds its
// transfer, the input register fills and s_axis_tready_o then drops;
// ready returns in the same cycle the receiver takes the result.
module dime_record_deframer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,  // [7:0] in_byte
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [7:0] data_byte, [8] record_flag_a, [9] record_flag_b, [10] type_is_uri,
  // [26:11] id_length, [42:27] type_length, [74:43] body_length, [79:75] zero
  output logic [dime_rd_pkg::TDATA_W-1:0]   m_axis_tdata_o,
  output logic [2:0]                        m_axis_tuser_o,  // [2:0] byte_class
  output logic                              m_axis_tlast_o   // section_last
);

  import dime_rd_pkg::*;

  logic       advance;
  logic       in_valid;
  logic [7:0] in_byte;
  result_t    res_new;
  result_t    res_out;

  dime_rd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .take_i  (advance),
    .valid_o (in_valid),
    .data_o  (in_byte)
  );

  dime_rd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_valid && advance),
    .byte_i (in_byte),
    .res_o  (res_new)
  );

  dime_rd_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_i     (res_new),
    .advance_o (advance),
    .ready_i   (m_axis_tready_i),
    .res_o     (res_out)
  );

  assign m_axis_tvalid_o = res_out.valid;
  assign m_axis_tuser_o  = res_out.byte_class;
  assign m_axis_tlast_o  = res_out.section_last;
  assign m_axis_tdata_o  = {5'b00000, res_out.body_length, res_out.type_length,
                            res_out.id_length, res_out.type_is_uri,
                            res_out.record_flag_b, res_out.record_flag_a,
                            res_out.data_byte};

  // nothing follows an error transfer
  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tuser_o == CLS_ERROR
    |=> !m_axis_tvalid_o)
    else $error("result after format error");

  a_last_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o
    |-> m_axis_tuser_o == CLS_ID || m_axis_tuser_o == CLS_TYPE ||
        m_axis_tuser_o == CLS_BODY)
    else $error("tlast on summary or error");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

endmodule

@@ rtl/dime_rd_in_reg.sv @@
module dime_rd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] data_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] data_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] data_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/dime_rd_parser.sv @@
module dime_rd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output dime_rd_pkg::result_t res_o
);

  import dime_rd_pkg::*;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] rem;
  } sect_t;

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [15:0] id_q, id_d;
  logic [15:0] ty_q, ty_d;
  logic [31:0] body_q, body_d;
  logic [2:0]  flags_q, flags_d;
  logic [31:0] rem_q, rem_d;
  logic [1:0]  pad_q, pad_d;

  logic        hdr_bad;
  logic [31:0] body_new;
  logic [1:0]  sec;
  logic [1:0]  pad_sec;
  logic [31:0] sec_len;
  logic [31:0] rem_dec;
  logic [1:0]  pad_dec;
  logic [1:0]  pad_need;

  // first non-empty section at or after s; header when none is left
  function automatic sect_t start_sec(input logic [1:0] s, input logic [15:0] id_len,
                                      input logic [15:0] ty_len, input logic [31:0] bd_len);
    sect_t r;
    r.phase = PH_HEADER;
    r.rem   = '0;
    if (s == 2'd0 && id_len != '0) begin
      r.phase = PH_ID;
      r.rem   = {16'h0000, id_len};
    end else if (s <= 2'd1 && ty_len != '0) begin
      r.phase = PH_TYPE;
      r.rem   = {16'h0000, ty_len};
    end else if (s <= 2'd2 && bd_len != '0) begin
      r.phase = PH_BODY;
      r.rem   = bd_len;
    end
    return r;
  endfunction

  assign body_new = {body_q[23:0], byte_i};
  assign sec      = 2'(phase_q - PH_ID);
  assign pad_sec  = 2'(phase_q - PH_PAD_ID);
  assign rem_dec  = rem_q - 32'd1;
  assign pad_dec  = pad_q - 2'd1;
  assign pad_need = 2'(~sec_len[1:0]) + 2'd1;

  always_comb begin
    unique case (sec)
      2'd0:    sec_len = {16'h0000, id_q};
      2'd1:    sec_len = {16'h0000, ty_q};
      default: sec_len = body_q;
    endcase
  end

  always_comb begin
    unique case (idx_q)
      HDR_IDX_FLAGS: hdr_bad = (byte_i & HDR_VER_MASK) != HDR_VER;
      HDR_IDX_TYPE:  hdr_bad = byte_i != HDR_TYPE_MEDIA && byte_i != HDR_TYPE_URI;
      HDR_IDX_RSV0,
      HDR_IDX_RSV1:  hdr_bad = byte_i != 8'h00;
      default:       hdr_bad = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    sect_t nxt;
    phase_d = phase_q;
    idx_d   = idx_q;
    id_d    = id_q;
    ty_d    = ty_q;
    body_d  = body_q;
    flags_d = flags_q;
    rem_d   = rem_q;
    pad_d   = pad_q;
    nxt     = start_sec(2'd0, id_q, ty_q, body_new);
    if (step_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          unique case (idx_q)
            HDR_IDX_FLAGS: flags_d = {1'b0, byte_i[1], byte_i[2]};
            HDR_IDX_TYPE: begin
              if (byte_i == HDR_TYPE_URI) begin
                flags_d = flags_q | 3'b100;
              end
            end
            HDR_IDX_RSV0, HDR_IDX_RSV1: ;
            HDR_IDX_ID_HI: id_d   = {byte_i, 8'h00};
            HDR_IDX_ID_LO: id_d   = {id_q[15:8], byte_i};
            HDR_IDX_TY_HI: ty_d   = {byte_i, 8'h00};
            HDR_IDX_TY_LO: ty_d   = {ty_q[15:8], byte_i};
            HDR_IDX_BODY:  body_d = {24'h000000, byte_i};
            default:       body_d = body_new;
          endcase
          if (hdr_bad) begin
            phase_d = PH_ERROR;
            idx_d   = '0;
          end else if (idx_q >= HDR_IDX_LAST) begin
            idx_d   = '0;
            nxt     = start_sec(2'd0, id_q, ty_q, body_new);
            phase_d = nxt.phase;
            rem_d   = nxt.rem;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        PH_ID, PH_TYPE, PH_BODY: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            if (pad_need != 2'd0) begin
              phase_d = phase_e'(PH_PAD_ID + {1'b0, sec});
              pad_d   = pad_need;
            end else begin
              nxt     = start_sec(sec + 2'd1, id_q, ty_q, body_q);
              phase_d = nxt.phase;
              rem_d   = nxt.rem;
            end
          end
        end
        PH_PAD_ID, PH_PAD_TYPE, PH_PAD_BODY: begin
          pad_d = pad_dec;
          if (pad_dec == 2'd0) begin
            nxt     = start_sec(pad_sec + 2'd1, id_q, ty_q, body_q);
            phase_d = nxt.phase;
            rem_d   = nxt.rem;
          end
        end
        default: ;
      endcase
    end
  end

  // result
  always_comb begin
    res_o = '0;
    if (step_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (hdr_bad) begin
            res_o.valid      = 1'b1;
            res_o.byte_class = CLS_ERROR;
          end else if (idx_q >= HDR_IDX_LAST) begin
            res_o.valid         = 1'b1;
            res_o.byte_class    = CLS_SUMMARY;
            res_o.record_flag_a = flags_q[0];
            res_o.record_flag_b = flags_q[1];
            res_o.type_is_uri   = flags_q[2];
            res_o.id_length     = id_q;
            res_o.type_length   = ty_q;
            res_o.body_length   = body_new;
          end
        end
        PH_ID, PH_TYPE, PH_BODY: begin
          res_o.valid        = 1'b1;
          res_o.data_byte    = byte_i;
          res_o.byte_class   = cls_e'({1'b0, sec});
          res_o.section_last = rem_dec == '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      idx_q   <= '0;
      id_q    <= '0;
      ty_q    <= '0;
      body_q  <= '0;
      flags_q <= '0;
      rem_q   <= '0;
      pad_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      id_q    <= id_d;
      ty_q    <= ty_d;
      body_q  <= body_d;
      flags_q <= flags_d;
      rem_q   <= rem_d;
      pad_q   <= pad_d;
    end
  end

endmodule

@@ rtl/dime_rd_out_reg.sv @@
module dime_rd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dime_rd_pkg::result_t res_i,
  output logic                 advance_o,
  input  logic                 ready_i,
  output dime_rd_pkg::result_t res_o
);

  import dime_rd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign advance_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = res_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_i.valid) begin
      res_q <= res_i;
    end
  end

  always_comb begin
    res_o       = res_q;
    res_o.valid = valid_q;
  end

endmodule

@@ dv/dime_rd_checker.sv @@
module dime_rd_checker
  import dime_rd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [7:0]          s_data_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [TDATA_W-1:0]  m_data_i,
  input  logic [2:0]          m_user_i,
  input  logic                m_last_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    cls_e        cls;
    logic [7:0]  data;
    logic        last;
    logic        flag_a;
    logic        flag_b;
    logic        uri;
    logic [15:0] id_len;
    logic [15:0] ty_len;
    logic [31:0] body_len;
  } dime_beat_t;

  dime_beat_t  beat_q[$];

  phase_e      rd_phase;
  logic [3:0]  hdr_pos;
  logic [15:0] id_len_q;
  logic [15:0] ty_len_q;
  logic [31:0] body_len_q;
  logic        flag_a_q;
  logic        flag_b_q;
  logic        uri_q;
  logic [31:0] sec_left;
  logic [1:0]  pad_left;

  // first: PH_ID, PH_TYPE or PH_BODY to start there, PH_HEADER for the next record
  function automatic void enter_from(phase_e first);
    if (first == PH_ID && id_len_q != '0) begin
      rd_phase = PH_ID;
      sec_left = 32'(id_len_q);
    end else if (first inside {PH_ID, PH_TYPE} && ty_len_q != '0) begin
      rd_phase = PH_TYPE;
      sec_left = 32'(ty_len_q);
    end else if (first != PH_HEADER && body_len_q != '0) begin
      rd_phase = PH_BODY;
      sec_left = body_len_q;
    end else begin
      rd_phase = PH_HEADER;
      hdr_pos  = '0;
      sec_left = '0;
    end
  endfunction

  function automatic void close_section(phase_e sec);
    logic [31:0] len;
    logic [1:0]  pad;
    phase_e      pad_ph;
    phase_e      next_ph;
    case (sec)
      PH_ID: begin
        len = 32'(id_len_q);
        pad_ph = PH_PAD_ID;
        next_ph = PH_TYPE;
      end
      PH_TYPE: begin
        len = 32'(ty_len_q);
        pad_ph = PH_PAD_TYPE;
        next_ph = PH_BODY;
      end
      default: begin
        len = body_len_q;
        pad_ph = PH_PAD_BODY;
        next_ph = PH_HEADER;
      end
    endcase
    pad = 2'(2'd0 - len[1:0]);
    if (pad != 2'd0) begin
      rd_phase = pad_ph;
      pad_left = pad;
    end else begin
      enter_from(next_ph);
    end
  endfunction

  function automatic bit predict_byte(input logic [7:0] b, output dime_beat_t e);
    bit bad;
    e = '0;
    bad = 1'b0;
    case (rd_phase)
      PH_HEADER: begin
        case (hdr_pos)
          HDR_IDX_FLAGS: begin
            bad = (b & HDR_VER_MASK) != HDR_VER;
            flag_a_q = b[2];
            flag_b_q = b[1];
            uri_q = 1'b0;
          end
          HDR_IDX_TYPE: begin
            if (b == HDR_TYPE_URI) uri_q = 1'b1;
            else if (b != HDR_TYPE_MEDIA) bad = 1'b1;
          end
          HDR_IDX_RSV0, HDR_IDX_RSV1: bad = (b != 8'h00);
          HDR_IDX_ID_HI: id_len_q = {b, 8'h00};
          HDR_IDX_ID_LO: id_len_q[7:0] = b;
          HDR_IDX_TY_HI: ty_len_q = {b, 8'h00};
          HDR_IDX_TY_LO: ty_len_q[7:0] = b;
          HDR_IDX_BODY:  body_len_q = {24'h0, b};
          default:       body_len_q = {body_len_q[23:0], b};
        endcase
        if (bad) begin
          rd_phase = PH_ERROR;
          hdr_pos = '0;
          e.cls = CLS_ERROR;
          return 1'b1;
        end
        if (hdr_pos >= HDR_IDX_LAST) begin
          e.cls = CLS_SUMMARY;
          e.flag_a = flag_a_q;
          e.flag_b = flag_b_q;
          e.uri = uri_q;
          e.id_len = id_len_q;
          e.ty_len = ty_len_q;
          e.body_len = body_len_q;
          hdr_pos = '0;
          enter_from(PH_ID);
          return 1'b1;
        end
        hdr_pos = hdr_pos + 4'd1;
        return 1'b0;
      end
      PH_ID, PH_TYPE, PH_BODY: begin
        e.data = b;
        e.cls = (rd_phase == PH_ID) ? CLS_ID : (rd_phase == PH_TYPE) ? CLS_TYPE : CLS_BODY;
        sec_left = sec_left - 32'd1;
        if (sec_left == '0) begin
          e.last = 1'b1;
          close_section(rd_phase);
        end
        return 1'b1;
      end
      PH_PAD_ID, PH_PAD_TYPE, PH_PAD_BODY: begin
        pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) begin
          enter_from(rd_phase == PH_PAD_ID ? PH_TYPE :
                     rd_phase == PH_PAD_TYPE ? PH_BODY : PH_HEADER);
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic string beat_str(dime_beat_t x);
    return $sformatf("cls=%0d data=%02h last=%0b a=%0b b=%0b uri=%0b id=%0d ty=%0d body=%0d",
                     x.cls, x.data, x.last, x.flag_a, x.flag_b, x.uri,
                     x.id_len, x.ty_len, x.body_len);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dime_beat_t want;
    dime_beat_t got;
    if (!rst_ni) begin
      beat_q.delete();
      rd_phase = PH_HEADER;
      hdr_pos = '0;
      id_len_q = '0;
      ty_len_q = '0;
      body_len_q = '0;
      flag_a_q = 1'b0;
      flag_b_q = 1'b0;
      uri_q = 1'b0;
      sec_left = '0;
      pad_left = '0;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        got.cls = cls_e'(m_user_i);
        got.data = m_data_i[7:0];
        got.last = m_last_i;
        got.flag_a = m_data_i[8];
        got.flag_b = m_data_i[9];
        got.uri = m_data_i[10];
        got.id_len = m_data_i[26:11];
        got.ty_len = m_data_i[42:27];
        got.body_len = m_data_i[74:43];
        if (beat_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 100)
            $display("%0t: unexpected transfer, expected none, got %s", $time, beat_str(got));
        end else begin
          want = beat_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 100)
              $display("%0t: mismatch, expected %s, got %s", $time, beat_str(want),
                       beat_str(got));
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        if (predict_byte(s_data_i, want)) beat_q.push_back(want);
      end
      pending_o = beat_q.size();
    end
  end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  import dime_rd_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int LongHold  = 400;

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [7:0]         s_data = 8'h00;
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [TDATA_W-1:0] m_data;
  logic [2:0]         m_user;
  logic               m_last;

  int fail_count;
  int pending;
  int sent_bytes = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  bit tx_gaps_on = 1'b0;
  bit rx_gaps_on = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  dime_record_deframer_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  dime_rd_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .m_user_i     (m_user),
    .m_last_i     (m_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver side: random stalls, one long hold-off while the sender keeps offering
  always @(negedge clk_i) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      rx_wait = LongHold;
      m_ready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait--;
      m_ready <= 1'b0;
    end else if (!rx_gaps_on) begin
      m_ready <= 1'b1;
    end else begin
      rx_wait = pick_gap();
      m_ready <= (rx_wait == 0);
      if (rx_wait != 0) rx_wait--;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    do @(posedge clk_i); while (!s_ready);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  task automatic put_section(input logic [31:0] n);
    logic [1:0] pad;
    pad = 2'(2'd0 - n[1:0]);
    repeat (n) put_byte(8'($urandom));
    repeat (pad) put_byte(8'($urandom));
  endtask

  task automatic put_record(input logic [7:0] lead, input bit uri, input logic [15:0] id_n,
                            input logic [15:0] ty_n, input logic [31:0] body_n);
    put_byte(lead);
    put_byte(uri ? HDR_TYPE_URI : HDR_TYPE_MEDIA);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(id_n[15:8]);
    put_byte(id_n[7:0]);
    put_byte(ty_n[15:8]);
    put_byte(ty_n[7:0]);
    put_byte(body_n[31:24]);
    put_byte(body_n[23:16]);
    put_byte(body_n[15:8]);
    put_byte(body_n[7:0]);
    put_section(32'(id_n));
    put_section(32'(ty_n));
    put_section(body_n);
  endtask

  initial begin
    logic [7:0]  bad_byte;
    logic [15:0] id_n;
    logic [15:0] ty_n;
    logic [31:0] body_n;
    int          bad_pos;

    repeat (12) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // directed records
    put_record(8'h08, 1'b0, 16'd0, 16'd0, 32'd0);
    put_record(8'h0F, 1'b1, 16'd1, 16'd2, 32'd3);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    put_record(8'h0C, 1'b0, 16'd4, 16'd0, 32'd5);
    put_record(8'h0A, 1'b1, 16'd0, 16'd0, 32'd1);
    put_record(8'h09, 1'b0, 16'd0, 16'd3, 32'd0);
    put_record(8'h0B, 1'b1, 16'd7, 16'd6, 32'd8);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    put_record(8'h0E, 1'b1, 16'h0103, 16'h0081, 32'h0000_0102);

    // random well-formed records
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    long_hold_req = 1'b1;
    sent_bytes = 0;
    while (sent_bytes < 1300) begin
      tx_gaps_on = ($urandom_range(0, 7) != 0);
      rx_gaps_on = ($urandom_range(0, 7) != 0);
      id_n   = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      ty_n   = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      body_n = ($urandom_range(0, 4) == 0) ? 32'd0 :
               ($urandom_range(0, 15) == 0) ? 32'($urandom_range(25, 300)) :
               32'($urandom_range(1, 24));
      put_record({5'b00001, 3'($urandom)}, 1'($urandom), id_n, ty_n, body_n);
    end

    // one bad header byte, then the block drops everything
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    bad_pos = $urandom_range(0, 3);
    case (bad_pos)
      0: begin
        do bad_byte = 8'($urandom); while ((bad_byte & HDR_VER_MASK) == HDR_VER);
        put_byte(bad_byte);
      end
      1: begin
        do bad_byte = 8'($urandom);
        while (bad_byte == HDR_TYPE_MEDIA || bad_byte == HDR_TYPE_URI);
        put_byte({5'b00001, 3'($urandom)});
        put_byte(bad_byte);
      end
      default: begin
        bad_byte = 8'($urandom_range(1, 255));
        put_byte({5'b00001, 3'($urandom)});
        put_byte(HDR_TYPE_MEDIA);
        if (bad_pos == 3) put_byte(8'h00);
        put_byte(bad_byte);
      end
    endcase
    put_record(8'h08, 1'b0, 16'd2, 16'd1, 32'd3);
    repeat (20) put_byte(8'($urandom));
    s_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
